[hw/rtl/rmp_pkg.sv]
// Shared constants and types for the ROI max pooling block.
`timescale 1ns / 1ps
package rmp_pkg;

  localparam int MAX_MAP_HEIGHT  = 64;
  localparam int MAX_MAP_WIDTH   = 64;
  localparam int MAX_CHANNELS    = 16;
  localparam int MAX_POOLED_SIDE = 8;
  localparam int VALUE_BITS      = 16;

  localparam int ROW_BITS    = $clog2(MAX_MAP_HEIGHT);
  localparam int COL_BITS    = $clog2(MAX_MAP_WIDTH);
  localparam int CH_BITS     = $clog2(MAX_CHANNELS);
  localparam int ADDR_BITS   = 16;
  localparam int EDGE_BITS   = 7;
  localparam int IN_CRD_BITS = 12;
  localparam int CRD_BITS    = 13;
  localparam int SCALE_BITS  = 17;
  localparam int PSIDE_BITS  = 4;
  localparam int PCNT_BITS   = 3;
  localparam int NUM_BITS    = 16;
  localparam int IDX_BITS    = 13;
  localparam int BIN_BITS    = 6;
  localparam int PADDR_BITS  = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POOL = 1'b1;

  localparam logic [2:0] REG_POOLED_HEIGHT = 3'd0;
  localparam logic [2:0] REG_POOLED_WIDTH  = 3'd1;
  localparam logic [2:0] REG_COORD_SCALE   = 3'd2;
  localparam logic [2:0] REG_MAP_HEIGHT    = 3'd3;
  localparam logic [2:0] REG_MAP_WIDTH     = 3'd4;
  localparam logic [2:0] REG_MAP_CHANNELS  = 3'd5;

  typedef struct packed {
    logic [3:0]  pooled_height;
    logic [3:0]  pooled_width;
    logic [16:0] coord_scale;
    logic [6:0]  map_height;
    logic [6:0]  map_width;
    logic [4:0]  map_channels;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [NUM_BITS-1:0]   dividend;
    logic [PSIDE_BITS-1:0] divisor;
  } div_req_t;

endpackage

[hw/rtl/rmp_cfg.sv]
// APB-style configuration registers of the ROI max pooling block.
`timescale 1ns / 1ps
module rmp_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rmp_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output rmp_pkg::cfg_t                  cfg
);
  import rmp_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pooled_height <= 4'd6;
      cfg_r.pooled_width  <= 4'd6;
      cfg_r.coord_scale   <= 17'd4096;
      cfg_r.map_height    <= 7'd64;
      cfg_r.map_width     <= 7'd64;
      cfg_r.map_channels  <= 5'd16;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POOLED_HEIGHT: cfg_r.pooled_height <= pwdata[3:0];
        REG_POOLED_WIDTH:  cfg_r.pooled_width  <= pwdata[3:0];
        REG_COORD_SCALE:   cfg_r.coord_scale   <= pwdata[16:0];
        REG_MAP_HEIGHT:    cfg_r.map_height    <= pwdata[6:0];
        REG_MAP_WIDTH:     cfg_r.map_width     <= pwdata[6:0];
        REG_MAP_CHANNELS:  cfg_r.map_channels  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POOLED_HEIGHT: prdata = {28'd0, cfg_r.pooled_height};
      REG_POOLED_WIDTH:  prdata = {28'd0, cfg_r.pooled_width};
      REG_COORD_SCALE:   prdata = {15'd0, cfg_r.coord_scale};
      REG_MAP_HEIGHT:    prdata = {25'd0, cfg_r.map_height};
      REG_MAP_WIDTH:     prdata = {25'd0, cfg_r.map_width};
      REG_MAP_CHANNELS:  prdata = {27'd0, cfg_r.map_channels};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

[hw/rtl/rmp_div.sv]
// Radix-2 restoring divider for bin edges, one quotient bit per cycle.
`timescale 1ns / 1ps
module rmp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rmp_pkg::div_req_t            req,
  output logic                         done,
  output logic [rmp_pkg::NUM_BITS-1:0] quotient
);
  import rmp_pkg::*;

  localparam int CNT_BITS = $clog2(NUM_BITS);

  logic [NUM_BITS-1:0]   quo_r;
  logic [PSIDE_BITS:0]   rem_r;
  logic [PSIDE_BITS-1:0] dvs_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [PSIDE_BITS:0]   rem_s;
  logic                  q_bit;

  // remainder stays below the divisor, so one bit of headroom is enough
  assign rem_s = {rem_r[PSIDE_BITS-1:0], quo_r[NUM_BITS-1]};
  assign q_bit = (rem_s >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(NUM_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_BITS-2:0], q_bit};
      rem_r <= q_bit ? (rem_s - {1'b0, dvs_r}) : rem_s;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/rmp_store.sv]
// Feature map store: one write port, one read port with registered data.
`timescale 1ns / 1ps
module rmp_store (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [rmp_pkg::ADDR_BITS-1:0]         wr_addr,
  input  logic signed [rmp_pkg::VALUE_BITS-1:0] wr_data,
  input  logic                                  rd_en,
  input  logic [rmp_pkg::ADDR_BITS-1:0]         rd_addr,
  output logic signed [rmp_pkg::VALUE_BITS-1:0] rd_data
);
  import rmp_pkg::*;

  localparam int DEPTH = MAX_CHANNELS * MAX_MAP_HEIGHT * MAX_MAP_WIDTH;

  logic signed [VALUE_BITS-1:0] mem [DEPTH];
  logic signed [VALUE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/roi_max_pooling_core.sv]
// ROI max pooling over one channel of a stored feature map.
// Usage:
//   Input channel (in_*): operation 0 writes in_value to the feature word at
//   in_address (channel*4096 + row*64 + column); operation 1 pools the ROI
//   in_roi_* (image pixels) on in_channel. Load items keep the block idle.
//   Result channel (out_*): one item per bin of the pooled grid, row-major,
//   out_last marks the final bin of the ROI. Loads give no result. The user
//   writes configuration (APB-style, pready tied high) while idle; unenforced.
// Sequence: one pool item runs the four corner scalings and the ROI size
//   step, then per bin an edge division for every bin side, each a numerator
//   step and a run on the shared serial divider, a scan of the bin's words
//   (none for an empty bin) at one store read per cycle and a drain state,
//   then the emit state that hands the bin to the output register once that
//   is free. The single store read port fixes the scan rate.
// Reset clears the control state and restores the register defaults; the
//   store content is not cleared and must be loaded before it is pooled.
// A stalled receiver holds the current bin in the output register and the
//   sequencer waits; a load may be taken while the last bin still waits.
`timescale 1ns / 1ps
module roi_max_pooling_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_operation,
  input  logic [15:0]                           in_address,
  input  logic signed [15:0]                    in_value,
  input  logic [3:0]                            in_channel,
  input  logic [11:0]                           in_roi_x1,
  input  logic [11:0]                           in_roi_y1,
  input  logic [11:0]                           in_roi_x2,
  input  logic [11:0]                           in_roi_y2,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [15:0]                    out_pooled_value,
  output logic signed [12:0]                    out_max_index,
  output logic [5:0]                            out_bin_index,
  output logic                                  out_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rmp_pkg::PADDR_BITS-1:0]        paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import rmp_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCALE = 8'b0000_0010,
    ST_SIZE  = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_SCAN  = 8'b0010_0000,
    ST_DRAIN = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  cfg_t cfg;

  state_t state_r, state_nxt;

  logic [CH_BITS-1:0]     ch_r;
  logic                   ch_ok_r;
  logic [IN_CRD_BITS-1:0] roi_r   [4];
  logic [CRD_BITS-1:0]    coord_r [4];
  logic [1:0]             step_r;
  logic [CRD_BITS-1:0]    rh_r, rw_r;
  logic [NUM_BITS-1:0]    numer_r;
  logic                   div_go_r;
  logic [PCNT_BITS-1:0]   ph_r, pw_r;
  logic [EDGE_BITS-1:0]   hs_r, he_r, ws_r, we_r;
  logic [ROW_BITS-1:0]    h_r;
  logic [COL_BITS-1:0]    w_r;
  logic                   rd_v_r;
  logic [IDX_BITS-1:0]    rd_idx_r;
  logic                   found_r;
  logic signed [VALUE_BITS-1:0] best_r;
  logic signed [IDX_BITS-1:0]   best_idx_r;

  logic                         out_valid_r;
  logic signed [VALUE_BITS-1:0] out_value_r;
  logic signed [IDX_BITS-1:0]   out_idx_r;
  logic [BIN_BITS-1:0]          out_bin_r;
  logic                         out_last_r;

  // clamped configuration
  logic [PSIDE_BITS-1:0] np_h, np_w;
  logic [EDGE_BITS-1:0]  mh, mw;
  logic [4:0]            mc;

  always_comb begin
    if (cfg.pooled_height == 4'd0) np_h = 4'd1;
    else if (cfg.pooled_height > 4'(MAX_POOLED_SIDE)) np_h = 4'(MAX_POOLED_SIDE);
    else np_h = cfg.pooled_height;
    if (cfg.pooled_width == 4'd0) np_w = 4'd1;
    else if (cfg.pooled_width > 4'(MAX_POOLED_SIDE)) np_w = 4'(MAX_POOLED_SIDE);
    else np_w = cfg.pooled_width;
    mh = (cfg.map_height > 7'(MAX_MAP_HEIGHT)) ? 7'(MAX_MAP_HEIGHT) : cfg.map_height;
    mw = (cfg.map_width > 7'(MAX_MAP_WIDTH)) ? 7'(MAX_MAP_WIDTH) : cfg.map_width;
    mc = (cfg.map_channels > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : cfg.map_channels;
  end

  logic in_acc, load_acc, pool_acc;
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign load_acc = in_acc && (in_operation == OP_LOAD);
  assign pool_acc = in_acc && (in_operation == OP_POOL);

  // corner scaling, rounding half up
  logic [29:0] scl_prod;
  assign scl_prod = 30'(roi_r[step_r]) * 30'(cfg.coord_scale) + 30'd32768;

  // edge numerator: side * k (+ side count - 1 for the ceiling)
  logic [CRD_BITS-1:0]   side_sel;
  logic [PSIDE_BITS-1:0] k_sel, np_sel;
  logic [20:0]           numer_full;
  always_comb begin
    side_sel   = step_r[1] ? rw_r : rh_r;
    np_sel     = step_r[1] ? np_w : np_h;
    k_sel      = {1'b0, (step_r[1] ? pw_r : ph_r)} + {3'd0, step_r[0]};
    numer_full = 21'(side_sel) * 21'(k_sel)
               + (step_r[0] ? 21'(np_sel - 4'd1) : 21'd0);
  end

  div_req_t            div_req;
  logic                div_done;
  logic [NUM_BITS-1:0] div_quo;

  assign div_req.start    = div_go_r;
  assign div_req.dividend = numer_r;
  assign div_req.divisor  = step_r[1] ? np_w : np_h;

  rmp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // edge = quotient + ROI corner, clipped to the map side
  logic [NUM_BITS:0]    edge_sum;
  logic [EDGE_BITS-1:0] edge_clip;
  always_comb begin
    edge_sum  = {1'b0, div_quo}
              + (NUM_BITS+1)'(step_r[1] ? coord_r[0] : coord_r[1]);
    if (step_r[1]) edge_clip = (edge_sum > (NUM_BITS+1)'(mw)) ? mw : edge_sum[EDGE_BITS-1:0];
    else edge_clip = (edge_sum > (NUM_BITS+1)'(mh)) ? mh : edge_sum[EDGE_BITS-1:0];
  end

  logic bin_full;
  assign bin_full = ch_ok_r && (hs_r < he_r) && (ws_r < edge_clip);

  // scan position
  logic w_wrap, h_last;
  assign w_wrap = ({1'b0, w_r} + 7'd1) == we_r;
  assign h_last = ({1'b0, h_r} + 7'd1) == he_r;

  logic [ADDR_BITS-1:0]         rd_addr;
  logic signed [VALUE_BITS-1:0] rd_data;
  assign rd_addr = ADDR_BITS'({ch_r, h_r, w_r});

  rmp_store u_store (
    .clk     (clk),
    .wr_en   (load_acc),
    .wr_addr (in_address),
    .wr_data (in_value),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic emit_go, bin_last;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign bin_last = ({1'b0, ph_r} == np_h - 4'd1) && ({1'b0, pw_r} == np_w - 4'd1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (pool_acc) state_nxt = ST_SCALE;
      ST_SCALE: if (step_r == 2'd3) state_nxt = ST_SIZE;
      ST_SIZE:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (step_r != 2'd3) state_nxt = ST_MUL;
          else if (bin_full) state_nxt = ST_SCAN;
          else state_nxt = ST_EMIT;
        end
      end
      ST_SCAN:  if (w_wrap && h_last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_go) state_nxt = bin_last ? ST_IDLE : ST_MUL;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 2'd0;
      div_go_r    <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= (state_r == ST_MUL);
      rd_v_r   <= (state_r == ST_SCAN);
      if (pool_acc) step_r <= 2'd0;
      else if (state_r == ST_SCALE) step_r <= step_r + 2'd1;
      else if (state_r == ST_DIV && div_done) step_r <= step_r + 2'd1;
      else if (emit_go) step_r <= 2'd0;
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pool_acc) begin
      ch_r     <= in_channel;
      ch_ok_r  <= ({1'b0, in_channel} < mc);
      roi_r[0] <= in_roi_x1;
      roi_r[1] <= in_roi_y1;
      roi_r[2] <= in_roi_x2;
      roi_r[3] <= in_roi_y2;
      ph_r     <= '0;
      pw_r     <= '0;
    end
    if (state_r == ST_SCALE) coord_r[step_r] <= scl_prod[28:16];
    if (state_r == ST_SIZE) begin
      rh_r <= (coord_r[3] >= coord_r[1]) ? (coord_r[3] - coord_r[1] + 13'd1) : 13'd1;
      rw_r <= (coord_r[2] >= coord_r[0]) ? (coord_r[2] - coord_r[0] + 13'd1) : 13'd1;
    end
    if (state_r == ST_MUL) numer_r <= numer_full[NUM_BITS-1:0];
    if (state_r == ST_DIV && div_done) begin
      unique case (step_r)
        2'd0: hs_r <= edge_clip;
        2'd1: he_r <= edge_clip;
        2'd2: ws_r <= edge_clip;
        2'd3: we_r <= edge_clip;
        default: ;
      endcase
      if (step_r == 2'd3) begin
        h_r <= hs_r[ROW_BITS-1:0];
        w_r <= ws_r[COL_BITS-1:0];
      end
    end
    if (state_r == ST_SCAN) begin
      rd_idx_r <= IDX_BITS'(h_r) * IDX_BITS'(mw) + IDX_BITS'(w_r);
      if (w_wrap) begin
        w_r <= ws_r[COL_BITS-1:0];
        h_r <= h_r + 1'b1;
      end else begin
        w_r <= w_r + 1'b1;
      end
    end
    // first word of the bin, or a strictly larger one, takes the lead
    if (state_r == ST_DIV && div_done && step_r == 2'd3) begin
      found_r    <= 1'b0;
      best_r     <= '0;
      best_idx_r <= '1;
    end else if (rd_v_r && (!found_r || rd_data > best_r)) begin
      found_r    <= 1'b1;
      best_r     <= rd_data;
      best_idx_r <= rd_idx_r;
    end
    if (emit_go) begin
      out_value_r <= best_r;
      out_idx_r   <= best_idx_r;
      out_bin_r   <= BIN_BITS'(ph_r) * BIN_BITS'(np_w) + BIN_BITS'(pw_r);
      out_last_r  <= bin_last;
      if ({1'b0, pw_r} == np_w - 4'd1) begin
        pw_r <= '0;
        ph_r <= ph_r + 1'b1;
      end else begin
        pw_r <= pw_r + 1'b1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pooled_value = out_value_r;
  assign out_max_index    = out_idx_r;
  assign out_bin_index    = out_bin_r;
  assign out_last         = out_last_r;

  rmp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

endmodule

[dv/tb.sv]
// Testbench for roi_max_pooling_core: random and directed loads and ROI pools, self-checked.
`timescale 1ns / 1ps
module tb;
  import rmp_pkg::*;

  localparam int LIMIT_CYCLES  = 8000000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int FILL_SIDE     = 6;
  localparam int FILL_CHANNELS = 2;

  typedef struct {
    logic        op;
    logic [15:0] addr;
    logic [15:0] val;
    logic [3:0]  ch;
    logic [11:0] x1, y1, x2, y2;
  } req_t;

  typedef struct {
    logic signed [15:0] pooled;
    logic signed [12:0] idx;
    logic [5:0]         bin;
    logic               last;
  } bin_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = OP_LOAD;
  logic [15:0] in_address = '0;
  logic signed [15:0] in_value = '0;
  logic [3:0] in_channel = '0;
  logic [11:0] in_roi_x1 = '0, in_roi_y1 = '0, in_roi_x2 = '0, in_roi_y2 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_pooled_value;
  logic signed [12:0] out_max_index;
  logic [5:0] out_bin_index;
  logic out_last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // shadow copy of the block's store and registers
  logic signed [15:0] feat_mem [0:65535];
  bit          wr_seen [0:65535];
  logic [3:0]  sh_ph = 4'd6, sh_pw = 4'd6;
  logic [16:0] sh_scale = 17'd4096;
  logic [6:0]  sh_mh = 7'd64, sh_mw = 7'd64;
  logic [4:0]  sh_mc = 5'd16;

  bin_t bins_due[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b1;
  int stall_left = 0;

  roi_max_pooling_core dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 18);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    bin_t e;
    if (rst_n && out_valid && out_ready) begin
      if (bins_due.size() == 0) begin
        $display("%0t unexpected bin: value %0d idx %0d bin %0d", $time,
                 out_pooled_value, out_max_index, out_bin_index);
        errors++;
      end else begin
        e = bins_due.pop_front();
        if (out_pooled_value !== e.pooled) begin
          $display("%0t pooled_value exp %0d got %0d", $time, e.pooled, out_pooled_value);
          errors++;
        end
        if (out_max_index !== e.idx) begin
          $display("%0t max_index exp %0d got %0d", $time, e.idx, out_max_index);
          errors++;
        end
        if (out_bin_index !== e.bin) begin
          $display("%0t bin_index exp %0d got %0d", $time, e.bin, out_bin_index);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t last exp %0d got %0d", $time, e.last, out_last);
          errors++;
        end
      end
    end
  end

  function automatic int scale_crd(logic [11:0] c);
    longint p;
    p = longint'(c) * longint'(sh_scale) + 32768;
    return int'(p >>> 16);
  endfunction

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  // bin edge: floor, or ceiling when up is set, offset by the ROI corner
  function automatic int bin_edge(int side, int k, int np, int org, int hi, bit up);
    return clip((side * k + (up ? np - 1 : 0)) / np + org, hi);
  endfunction

  // true when no bin of the pool reaches a word that was never loaded
  function automatic bit pool_safe(req_t r);
    int nph, npw, mh, mw, x1, y1, rh, rw, hs, he, ws, we, a;
    bit ch_ok;
    nph = (sh_ph == 0) ? 1 : (sh_ph > MAX_POOLED_SIDE) ? MAX_POOLED_SIDE : sh_ph;
    npw = (sh_pw == 0) ? 1 : (sh_pw > MAX_POOLED_SIDE) ? MAX_POOLED_SIDE : sh_pw;
    mh = (sh_mh > MAX_MAP_HEIGHT) ? MAX_MAP_HEIGHT : sh_mh;
    mw = (sh_mw > MAX_MAP_WIDTH) ? MAX_MAP_WIDTH : sh_mw;
    ch_ok = r.ch < ((sh_mc > MAX_CHANNELS) ? MAX_CHANNELS : sh_mc);
    if (!ch_ok) return 1'b1;
    x1 = scale_crd(r.x1);
    y1 = scale_crd(r.y1);
    rh = (scale_crd(r.y2) - y1 + 1 < 1) ? 1 : scale_crd(r.y2) - y1 + 1;
    rw = (scale_crd(r.x2) - x1 + 1 < 1) ? 1 : scale_crd(r.x2) - x1 + 1;
    for (int ph = 0; ph < nph; ph++) begin
      hs = bin_edge(rh, ph, nph, y1, mh, 1'b0);
      he = bin_edge(rh, ph + 1, nph, y1, mh, 1'b1);
      for (int pw = 0; pw < npw; pw++) begin
        ws = bin_edge(rw, pw, npw, x1, mw, 1'b0);
        we = bin_edge(rw, pw + 1, npw, x1, mw, 1'b1);
        for (int h = hs; h < he; h++) begin
          for (int w = ws; w < we; w++) begin
            a = int'(r.ch) * 4096 + h * 64 + w;
            if (!wr_seen[a]) return 1'b0;
          end
        end
      end
    end
    return 1'b1;
  endfunction

  // expected bins of one pool item
  task automatic predict_pool(req_t r);
    int nph, npw, mh, mw, x1, y1, x2, y2, rh, rw, hs, he, ws, we, best, bidx, total, n;
    bit ch_ok, found;
    bin_t b;
    nph = (sh_ph == 0) ? 1 : (sh_ph > MAX_POOLED_SIDE) ? MAX_POOLED_SIDE : sh_ph;
    npw = (sh_pw == 0) ? 1 : (sh_pw > MAX_POOLED_SIDE) ? MAX_POOLED_SIDE : sh_pw;
    mh = (sh_mh > MAX_MAP_HEIGHT) ? MAX_MAP_HEIGHT : sh_mh;
    mw = (sh_mw > MAX_MAP_WIDTH) ? MAX_MAP_WIDTH : sh_mw;
    ch_ok = r.ch < ((sh_mc > MAX_CHANNELS) ? MAX_CHANNELS : sh_mc);
    x1 = scale_crd(r.x1);
    y1 = scale_crd(r.y1);
    x2 = scale_crd(r.x2);
    y2 = scale_crd(r.y2);
    rh = (y2 - y1 + 1 < 1) ? 1 : y2 - y1 + 1;
    rw = (x2 - x1 + 1 < 1) ? 1 : x2 - x1 + 1;
    total = nph * npw;
    n = 0;
    for (int ph = 0; ph < nph; ph++) begin
      hs = bin_edge(rh, ph, nph, y1, mh, 1'b0);
      he = bin_edge(rh, ph + 1, nph, y1, mh, 1'b1);
      for (int pw = 0; pw < npw; pw++) begin
        ws = bin_edge(rw, pw, npw, x1, mw, 1'b0);
        we = bin_edge(rw, pw + 1, npw, x1, mw, 1'b1);
        best = 0;
        bidx = -1;
        found = 1'b0;
        if (ch_ok && hs < he && ws < we) begin
          for (int h = hs; h < he; h++) begin
            for (int w = ws; w < we; w++) begin
              if (!found || int'(feat_mem[r.ch * 4096 + h * 64 + w]) > best) begin
                found = 1'b1;
                best = feat_mem[r.ch * 4096 + h * 64 + w];
                bidx = h * mw + w;
              end
            end
          end
        end
        b.pooled = best[15:0];
        b.idx = bidx[12:0];
        b.bin = 6'(ph * npw + pw);
        b.last = (n == total - 1);
        bins_due.push_back(b);
        n++;
      end
    end
  endtask

  task automatic send_item(req_t r);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation <= r.op;
    in_address <= r.addr;
    in_value <= r.val;
    in_channel <= r.ch;
    in_roi_x1 <= r.x1;
    in_roi_y1 <= r.y1;
    in_roi_x2 <= r.x2;
    in_roi_y2 <= r.y2;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (r.op == OP_LOAD) begin
      feat_mem[r.addr] = r.val;
      wr_seen[r.addr] = 1'b1;
    end else begin
      predict_pool(r);
    end
  endtask

  task automatic load_word(int ch, int row, int col, logic [15:0] v);
    req_t r;
    r = '{OP_LOAD, 16'(ch * 4096 + row * 64 + col), v, 4'd0, 12'd0, 12'd0, 12'd0, 12'd0};
    send_item(r);
  endtask

  // a pool that would reach an unloaded word falls back to a 1x1 ROI on the
  // origin of channel 0, which the fill always covers
  task automatic pool(logic [3:0] ch, logic [11:0] x1, y1, x2, y2);
    req_t r;
    r = '{OP_POOL, 16'($urandom), 16'($urandom), ch, x1, y1, x2, y2};
    if (!pool_safe(r)) begin
      r = '{OP_POOL, 16'($urandom), 16'($urandom), 4'd0, 12'd0, 12'd0, 12'd0, 12'd0};
    end
    send_item(r);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_BITS'(idx * 4);
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POOLED_HEIGHT: sh_ph = data[3:0];
      REG_POOLED_WIDTH:  sh_pw = data[3:0];
      REG_COORD_SCALE:   sh_scale = data[16:0];
      REG_MAP_HEIGHT:    sh_mh = data[6:0];
      REG_MAP_WIDTH:     sh_mw = data[6:0];
      REG_MAP_CHANNELS:  sh_mc = data[4:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int ph, int pw, int sc, int mh, int mw, int mc);
    wait_idle();
    reg_write(REG_POOLED_HEIGHT, ph);
    reg_write(REG_POOLED_WIDTH, pw);
    reg_write(REG_COORD_SCALE, sc);
    reg_write(REG_MAP_HEIGHT, mh);
    reg_write(REG_MAP_WIDTH, mw);
    reg_write(REG_MAP_CHANNELS, mc);
  endtask

  // the corner of the first channels that the pools stay within
  task automatic test_fill_store();
    for (int ch = 0; ch < FILL_CHANNELS; ch++) begin
      for (int row = 0; row < FILL_SIDE; row++) begin
        for (int col = 0; col < FILL_SIDE; col++) begin
          load_word(ch, row, col, 16'($urandom));
        end
      end
    end
  endtask

  task automatic test_directed();
    load_word(0, 0, 0, 16'h7fff);
    load_word(0, 0, 1, 16'h8000);
    load_word(1, 2, 2, 16'h0123);
    load_word(1, 2, 3, 16'h0123);
    load_word(1, 3, 2, 16'h0123);
    load_word(1, 3, 3, 16'h0123);
    pool(4'd0, 12'd0, 12'd0, 12'd80, 12'd80);        // one word per bin
    pool(4'd0, 12'd0, 12'd0, 12'd0, 12'd0);          // 1x1 ROI shared by all bins
    pool(4'd1, 12'd80, 12'd80, 12'd16, 12'd16);      // reversed corners
    pool(4'd15, 12'd4095, 12'd4095, 12'd4095, 12'd4095); // off the map
    set_regs(1, 1, 65536, 64, 64, 16);
    pool(4'd1, 12'd2, 12'd2, 12'd3, 12'd3);          // tie: first word wins
    pool(4'd0, 12'd0, 12'd0, 12'd1, 12'd0);
    set_regs(3, 2, 65536, 4, 3, 2);                  // ROI clipped by a small map
    pool(4'd1, 12'd0, 12'd0, 12'd5, 12'd5);
    set_regs(0, 15, 0, 127, 127, 1);                 // side clamps, zero scale
    pool(4'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    pool(4'd1, 12'd10, 12'd10, 12'd20, 12'd20);      // channel not in use
    set_regs(8, 8, 131071, 0, 64, 31);               // zero map height
    pool(4'd2, 12'd0, 12'd0, 12'd30, 12'd30);
    set_regs(8, 8, 65536, 64, 1, 0);
    pool(4'd0, 12'd0, 12'd0, 12'd63, 12'd63);
  endtask

  function automatic logic [11:0] to_image(int f);
    longint c;
    if (sh_scale == 0) return 12'($urandom);
    c = (longint'(f) * 65536) / longint'(sh_scale);
    return (c > 4095) ? 12'd4095 : 12'(c);
  endfunction

  task automatic random_items(int n);
    req_t r;
    int mh, mw, fx1, fy1, fx2, fy2, tries;
    for (int i = 0; i < n; i++) begin
      mh = (sh_mh == 0) ? 1 : (sh_mh > FILL_SIDE) ? FILL_SIDE : sh_mh;
      mw = (sh_mw == 0) ? 1 : (sh_mw > FILL_SIDE) ? FILL_SIDE : sh_mw;
      if ($urandom_range(0, 2) == 0) begin
        r = '{OP_LOAD, 16'($urandom), 16'($urandom), 4'($urandom), 12'($urandom),
              12'($urandom), 12'($urandom), 12'($urandom)};
        send_item(r);
      end else if ($urandom_range(0, 3) != 0) begin
        fx1 = $urandom_range(0, mw - 1);
        fy1 = $urandom_range(0, mh - 1);
        fx2 = $urandom_range(fx1, mw - 1);
        fy2 = $urandom_range(fy1, mh - 1);
        pool(4'($urandom_range(0, FILL_CHANNELS - 1)), to_image(fx1), to_image(fy1),
             to_image(fx2), to_image(fy2));
      end else begin
        tries = 0;
        do begin
          r = '{OP_POOL, 16'($urandom), 16'($urandom), 4'($urandom), 12'($urandom),
                12'($urandom), 12'($urandom), 12'($urandom)};
          tries++;
        end while (!pool_safe(r) && tries < 8);
        pool(r.ch, r.x1, r.y1, r.x2, r.y2);
      end
    end
  endtask

  task automatic test_random();
    set_regs(6, 6, 4096, 64, 64, 16);
    random_items(10);
    set_regs(3, 5, 20000, 40, 37, 9);
    random_items(10);
    set_regs(8, 8, 65536, 64, 64, 16);
    random_items(10);
    set_regs(1, 1, 1, 1, 1, 1);
    random_items(8);
    set_regs(7, 2, 30000, 127, 127, 31);
    random_items(8);
    quiet = 1'b1;
    set_regs(4, 4, 16384, 6, 6, 2);
    random_items(8);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_fill_store();
    quiet = 1'b0;
    test_directed();
    test_random();
    wait_idle();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
